// File: rtl/msmv_pkg.sv
// shared constants, types and arithmetic helpers of the matrix store
package msmv_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int DIM_W     = 5;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 4;

    localparam int S_TDATA_W = ((ROW_W + COL_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + ROW_W + 7) / 8) * 8;

    localparam int PROD_W    = 2 * DATA_W;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int ACC_W     = RND_W + $clog2(MAX_COLS);

    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [DIM_W-1:0] VCNT_MAX  = DIM_W'(2 ** DIM_W - 1);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);
    localparam longint ROUND_HALF = 2 ** (FRAC_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SCALE  = 2'd2,
        CMD_VECTOR = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_LENGTH = 2'd2
    } t_status;

    // element address and end marker carried along the multiply pipeline
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_tag;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] hi_bits;
        hi_bits = v[ACC_W-1:DATA_W-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

// File: rtl/msmv_ram.sv
// generic simple dual-port ram with registered read
module msmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/msmv_qmul.sv
// two-stage q16.16 multiplier with round half up, tag carried alongside
module msmv_qmul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  msmv_pkg::t_tag                      i_tag,
    input  logic signed [msmv_pkg::DATA_W-1:0]  i_a,
    input  logic signed [msmv_pkg::DATA_W-1:0]  i_b,
    output logic                                o_valid,
    output msmv_pkg::t_tag                      o_tag,
    output logic signed [msmv_pkg::RND_W-1:0]   o_round
);
    import msmv_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    t_tag                     r_tag1;
    t_tag                     r_tag2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RND_W-1:0]  r_round;
    logic signed [PROD_W-1:0] biased;

    assign biased = r_prod + $signed(PROD_W'(ROUND_HALF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= i_a * i_b;
        r_tag1  <= i_tag;
        // floor of the biased product over 2^16
        r_round <= biased[PROD_W-1:FRAC_W];
        r_tag2  <= r_tag1;
    end

    assign o_valid = r_v2;
    assign o_tag   = r_tag2;
    assign o_round = r_round;

endmodule

// File: rtl/matrix_store_scale_and_matvec.sv
// top level: q16.16 matrix store with element access, scaling and matrix-vector multiply
// A write or read item passes through S_EMIT (a read first through S_RD) into the output
// register; a vector element that is not last and in range is taken while the block stays
// idle. Scaling streams every active element through the single multiplier and the element
// ram. The multiply walks one row at a time through the same multiplier and ram, and emits
// one word per row. After reset and after every write to the row or column count the element
// ram is cleared in a pass over all 256 addresses during which no input word is accepted;
// configuration writes are always taken. A finished result waits in the output register while
// the next word is accepted.
module matrix_store_scale_and_matvec (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // row_index [3:0], col_index [7:4], value [39:8]
    input  logic [msmv_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,    // vector_last
    // command [1:0]
    input  logic [msmv_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // data [31:0], out_row [35:32], zero fill above
    output logic [msmv_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,    // last
    // status [1:0]
    output logic [msmv_pkg::STAT_W-1:0]        o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [msmv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msmv_pkg::DIM_W-1:0]         i_cfg_data
);
    import msmv_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EMIT,
        S_SC_RUN,
        S_SC_DRAIN,
        S_MV_RUN,
        S_MV_DRAIN,
        S_MV_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [DIM_W-1:0]  r_row_count;
    logic [DIM_W-1:0]  r_col_count;
    logic [DIM_W-1:0]  r_active_cols;
    logic [DIM_W-1:0]  r_vec_count;
    logic [ADDR_W-1:0] r_clr;
    logic [ROW_W-1:0]  r_ri;
    logic [COL_W-1:0]  r_ci;
    logic              r_t1_valid;
    t_tag              r_t1_tag;
    logic              r_row_done;
    logic              r_out_valid;

    logic signed [DATA_W-1:0] r_res_data;
    logic [ROW_W-1:0]         r_res_row;
    t_status                  r_res_status;
    logic signed [DATA_W-1:0] r_out_data;
    logic [ROW_W-1:0]         r_out_row;
    t_status                  r_out_status;
    logic                     r_out_last;
    logic signed [DATA_W-1:0] r_scale;
    logic signed [DATA_W-1:0] r_vec [MAX_COLS];
    logic signed [DATA_W-1:0] r_b1;
    logic signed [ACC_W-1:0]  r_acc;

    logic [ROW_W-1:0]         in_row;
    logic [COL_W-1:0]         in_col;
    logic signed [DATA_W-1:0] in_val;
    t_cmd                     in_cmd;
    logic [DIM_W-1:0]         rows;
    logic                     in_range;
    logic                     col_ok;
    logic                     accept;
    logic                     slot_free;
    logic                     cfg_we;
    logic [DIM_W-1:0]         vcnt_inc;
    logic                     ci_last;
    logic                     ri_last;
    logic                     issue;
    logic                     sc_mode;
    logic                     mv_mode;
    logic                     load_out;
    logic signed [DATA_W-1:0] acc_sat;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     q_valid;
    t_tag                     q_tag;
    logic signed [RND_W-1:0]  q_round;

    assign in_row = i_s_axis_tdata[ROW_W-1:0];
    assign in_col = i_s_axis_tdata[ROW_W +: COL_W];
    assign in_val = $signed(i_s_axis_tdata[ROW_W+COL_W +: DATA_W]);
    assign in_cmd = t_cmd'(i_s_axis_tuser);

    assign rows      = clamp_dim(r_row_count, DIM_W'(MAX_ROWS));
    assign col_ok    = DIM_W'(in_col) < r_active_cols;
    assign in_range  = (DIM_W'(in_row) < rows) && col_ok;
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign cfg_we    = i_cfg_valid && (i_cfg_index == CFG_ROW_COUNT ||
                                       i_cfg_index == CFG_COL_COUNT);
    assign vcnt_inc  = (r_vec_count < VCNT_MAX) ? r_vec_count + DIM_W'(1) : r_vec_count;
    assign ci_last   = DIM_W'(r_ci) == r_active_cols - DIM_W'(1);
    assign ri_last   = DIM_W'(r_ri) == rows - DIM_W'(1);
    assign sc_mode   = r_state == S_SC_RUN || r_state == S_SC_DRAIN;
    assign mv_mode   = r_state == S_MV_RUN || r_state == S_MV_DRAIN;
    assign issue     = r_state == S_SC_RUN || r_state == S_MV_RUN;
    assign load_out  = (r_state == S_EMIT || r_state == S_MV_EMIT) && slot_free;
    assign acc_sat   = sat_q(r_acc);

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-DATA_W-ROW_W){1'b0}}, r_out_row, r_out_data};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_status;

    // single write port: clearing, element write, scale write-back, product write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = elem_addr(r_ri, r_ci);
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                ram_raddr = elem_addr(in_row, in_col);
                if (accept && in_cmd == CMD_WRITE && in_range) begin
                    ram_we    = 1'b1;
                    ram_waddr = elem_addr(in_row, in_col);
                    ram_wdata = in_val;
                end
            end
            S_SC_RUN, S_SC_DRAIN: begin
                if (q_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = q_tag.addr;
                    ram_wdata = sat_q({{(ACC_W-RND_W){q_round[RND_W-1]}}, q_round});
                end
            end
            S_MV_EMIT: begin
                if (slot_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = elem_addr(r_ri, COL_W'(0));
                    ram_wdata = acc_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd) inside
                        CMD_WRITE, CMD_READ: begin
                            n_state = (in_range && in_cmd == CMD_READ) ? S_RD : S_EMIT;
                        end
                        CMD_SCALE: n_state = S_SC_RUN;
                        CMD_VECTOR: begin
                            if (!col_ok) begin
                                n_state = S_EMIT;
                            end else if (i_s_axis_tlast) begin
                                n_state = (vcnt_inc == r_active_cols) ? S_MV_RUN : S_EMIT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:       n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SC_RUN: begin
                if (ci_last && ri_last) begin
                    n_state = S_SC_DRAIN;
                end
            end
            S_SC_DRAIN: begin
                if (q_valid && q_tag.last) begin
                    n_state = S_EMIT;
                end
            end
            S_MV_RUN: begin
                if (ci_last) begin
                    n_state = S_MV_DRAIN;
                end
            end
            S_MV_DRAIN: begin
                if (r_row_done) begin
                    n_state = S_MV_EMIT;
                end
            end
            S_MV_EMIT: begin
                if (slot_free) begin
                    n_state = ri_last ? S_IDLE : S_MV_RUN;
                end
            end
            default:    n_state = S_IDLE;
        endcase
        if (cfg_we) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_row_count   <= DIM_RESET;
            r_col_count   <= DIM_RESET;
            r_active_cols <= clamp_dim(DIM_RESET, DIM_W'(MAX_COLS));
            r_vec_count   <= '0;
            r_clr         <= '0;
            r_ri          <= '0;
            r_ci          <= '0;
            r_t1_valid    <= 1'b0;
            r_row_done    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_data    <= '0;
            r_out_row     <= '0;
            r_out_status  <= ST_OK;
            r_out_last    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_t1_valid <= issue;

            if (load_out) begin
                r_out_valid <= 1'b1;
                if (r_state == S_MV_EMIT) begin
                    r_out_data   <= acc_sat;
                    r_out_row    <= r_ri;
                    r_out_status <= ST_OK;
                    r_out_last   <= ri_last;
                end else begin
                    r_out_data   <= r_res_data;
                    r_out_row    <= r_res_row;
                    r_out_status <= r_res_status;
                    r_out_last   <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (mv_mode && q_valid && q_tag.last) begin
                r_row_done <= 1'b1;
            end

            if (cfg_we) begin
                r_clr       <= '0;
                r_vec_count <= '0;
                if (i_cfg_index == CFG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data;
                end else begin
                    r_col_count   <= i_cfg_data;
                end
                r_active_cols <= clamp_dim((i_cfg_index == CFG_COL_COUNT) ? i_cfg_data
                                           : r_col_count, DIM_W'(MAX_COLS));
            end else begin
                unique case (r_state)
                    S_CLEAR: r_clr <= r_clr + ADDR_W'(1);
                    S_IDLE: begin
                        if (accept) begin
                            r_ri <= '0;
                            r_ci <= '0;
                            if (in_cmd == CMD_VECTOR) begin
                                // a last element always ends the vector, good or bad
                                if (i_s_axis_tlast) begin
                                    r_vec_count <= '0;
                                end else if (col_ok) begin
                                    r_vec_count <= vcnt_inc;
                                end
                            end
                        end
                    end
                    S_SC_RUN: begin
                        if (ci_last) begin
                            r_ci <= '0;
                            r_ri <= r_ri + ROW_W'(1);
                        end else begin
                            r_ci <= r_ci + COL_W'(1);
                        end
                    end
                    S_MV_RUN: begin
                        r_ci <= ci_last ? '0 : r_ci + COL_W'(1);
                    end
                    S_MV_EMIT: begin
                        if (slot_free) begin
                            r_row_done <= 1'b0;
                            if (ri_last) begin
                                r_active_cols <= DIM_W'(1);
                            end else begin
                                r_ri <= r_ri + ROW_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_scale      <= in_val;
            r_res_data   <= '0;
            r_res_row    <= '0;
            r_res_status <= ST_OK;
            case (in_cmd)
                CMD_WRITE, CMD_READ: begin
                    r_res_row    <= in_row;
                    r_res_status <= in_range ? ST_OK : ST_RANGE;
                    if (in_range && in_cmd == CMD_WRITE) begin
                        r_res_data <= in_val;
                    end
                end
                CMD_VECTOR: begin
                    r_res_status <= col_ok ? ST_LENGTH : ST_RANGE;
                    if (col_ok) begin
                        r_vec[in_col] <= in_val;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_RD) begin
            r_res_data <= $signed(ram_rdata);
        end

        r_b1     <= sc_mode ? r_scale : r_vec[r_ci];
        r_t1_tag <= '{addr: elem_addr(r_ri, r_ci),
                      last: (r_state == S_SC_RUN) ? (ci_last && ri_last) : ci_last};

        // row sum over wide accumulator, saturated once at emit
        if (r_state == S_IDLE || load_out) begin
            r_acc <= '0;
        end else if (mv_mode && q_valid) begin
            r_acc <= r_acc + {{(ACC_W-RND_W){q_round[RND_W-1]}}, q_round};
        end
    end

    msmv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    msmv_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t1_valid),
        .i_tag   (r_t1_tag),
        .i_a     ($signed(ram_rdata)),
        .i_b     (r_b1),
        .o_valid (q_valid),
        .o_tag   (q_tag),
        .o_round (q_round)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the q16.16 matrix store with scaling and matrix-vector multiply
module tb_top;
    import msmv_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam longint Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN     = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [ROW_W-1:0]         row;
        t_status                  status;
        logic                     last;
    } t_word;

    class matvec_scoreboard;
        logic signed [DATA_W-1:0] elems [MEM_DEPTH];
        logic signed [DATA_W-1:0] vec [MAX_COLS];
        bit                       vec_seen [MAX_COLS];
        logic [DIM_W-1:0]         row_reg;
        logic [DIM_W-1:0]         col_reg;
        int unsigned              vcount;
        int unsigned              acols;
        t_word                    expected_words [$];
        int                       errors;
        int                       words_seen;
        int                       matvecs;
        int                       cfg_writes;

        function new();
            errors = 0;
            words_seen = 0;
            matvecs = 0;
            cfg_writes = 0;
            reset_state();
        endfunction

        function int unsigned clamp16(logic [DIM_W-1:0] v);
            if (v == 0) begin
                return 1;
            end else if (v > MAX_COLS) begin
                return MAX_COLS;
            end
            return v;
        endfunction

        function int unsigned eff_rows();
            return clamp16(row_reg);
        endfunction

        function void clear_store();
            foreach (elems[i]) elems[i] = '0;
            acols = clamp16(col_reg);
            vcount = 0;
        endfunction

        function void reset_state();
            row_reg = DIM_W'(2);
            col_reg = DIM_W'(2);
            foreach (vec[i]) begin
                vec[i] = '0;
                vec_seen[i] = 1'b0;
            end
            clear_store();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
            cfg_writes++;
            if (idx == CFG_ROW_COUNT) begin
                row_reg = d;
                clear_store();
            end else if (idx == CFG_COL_COUNT) begin
                col_reg = d;
                clear_store();
            end
        endfunction

        // exact product, rounded half up to q16.16
        function longint q_mul(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return (p + ROUND_HALF) >>> FRAC_W;
        endfunction

        function logic signed [DATA_W-1:0] clip(longint v);
            if (v > Q_MAX) begin
                return {1'b0, {(DATA_W-1){1'b1}}};
            end else if (v < Q_MIN) begin
                return {1'b1, {(DATA_W-1){1'b0}}};
            end
            return DATA_W'(v);
        endfunction

        function void push_word(logic signed [DATA_W-1:0] d, int unsigned r, t_status s, bit l);
            t_word w;
            w.data = d;
            w.row = ROW_W'(r);
            w.status = s;
            w.last = l;
            expected_words.push_back(w);
        endfunction

        // true when this element would start a multiply over a never written position
        function bit multiply_unsafe(logic [COL_W-1:0] c, logic vlast);
            int unsigned nc;
            if (!vlast || c >= acols) begin
                return 1'b0;
            end
            nc = (vcount < 31) ? vcount + 1 : 31;
            if (nc != acols) begin
                return 1'b0;
            end
            for (int j = 0; j < acols; j++) begin
                if (j != c && !vec_seen[j]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_input(t_cmd cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                 logic signed [DATA_W-1:0] val, logic vlast);
            int unsigned rows;
            int unsigned addr;
            longint acc;
            logic signed [DATA_W-1:0] prod [MAX_ROWS];
            rows = eff_rows();
            case (cmd)
                CMD_WRITE, CMD_READ: begin
                    if (r >= rows || c >= acols) begin
                        push_word('0, r, ST_RANGE, 1'b1);
                    end else begin
                        addr = r * MAX_COLS + c;
                        if (cmd == CMD_WRITE) elems[addr] = val;
                        push_word(elems[addr], r, ST_OK, 1'b1);
                    end
                end
                CMD_SCALE: begin
                    for (int i = 0; i < rows; i++) begin
                        for (int j = 0; j < acols; j++) begin
                            elems[i * MAX_COLS + j] = clip(q_mul(elems[i * MAX_COLS + j], val));
                        end
                    end
                    push_word('0, 0, ST_OK, 1'b1);
                end
                default: begin
                    if (c >= acols) begin
                        if (vlast) vcount = 0;
                        push_word('0, 0, ST_RANGE, 1'b1);
                    end else begin
                        vec[c] = val;
                        vec_seen[c] = 1'b1;
                        if (vcount < 31) vcount++;
                        if (vlast && vcount != acols) begin
                            vcount = 0;
                            push_word('0, 0, ST_LENGTH, 1'b1);
                        end else if (vlast) begin
                            for (int i = 0; i < rows; i++) begin
                                acc = 0;
                                for (int j = 0; j < acols; j++) begin
                                    acc += q_mul(elems[i * MAX_COLS + j], vec[j]);
                                end
                                prod[i] = clip(acc);
                            end
                            for (int i = 0; i < rows; i++) begin
                                elems[i * MAX_COLS] = prod[i];
                                push_word(prod[i], i, ST_OK, i + 1 == rows);
                            end
                            acols = 1;
                            vcount = 0;
                            matvecs++;
                        end
                    end
                end
            endcase
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word: data %h row %0d status %0d last %0b",
                         $time, got.data, got.row, got.status, got.last);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            words_seen++;
            if (got.data !== want.data) begin
                $display("%0t: data mismatch: expected %h, actual %h", $time, want.data, got.data);
                errors++;
            end
            if (got.row !== want.row) begin
                $display("%0t: row mismatch: expected %0d, actual %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [S_TDATA_W-1:0]     i_s_axis_tdata = '0;
    logic                     i_s_axis_tlast = 1'b0;
    logic [CMD_W-1:0]         i_s_axis_tuser = '0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]     o_m_axis_tdata;
    logic                     o_m_axis_tlast;
    logic [STAT_W-1:0]        o_m_axis_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DIM_W-1:0]         i_cfg_data = '0;

    matvec_scoreboard sb = new();
    int idle_pct = 20;
    bit quiet = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    matrix_store_scale_and_matvec u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure in bursts that start at random, unless quiet
    initial begin : out_ready_gen
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(99) < idle_pct) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_word got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.data = o_m_axis_tdata[DATA_W-1:0];
            got.row = o_m_axis_tdata[DATA_W +: ROW_W];
            got.status = t_status'(o_m_axis_tuser);
            got.last = o_m_axis_tlast;
            sb.check_word(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words still expected",
                     $time, IDLE_LIMIT, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            3: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // mostly factors near +-1.0 so that the matrix neither dies out nor pins at the rails
    function automatic logic signed [DATA_W-1:0] rand_factor();
        logic signed [DATA_W-1:0] f;
        if ($urandom_range(0, 3) == 0) begin
            return rand_q();
        end
        f = $urandom_range(32'h0000_8000, 32'h0001_8000);
        if ($urandom_range(0, 1) == 1) f = -f;
        return f;
    endfunction

    task automatic send_item(t_cmd cmd, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic signed [DATA_W-1:0] val, logic vlast);
        if (!quiet && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {val, c, r};
        i_s_axis_tuser <= cmd;
        i_s_axis_tlast <= vlast;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(cmd, r, c, val, vlast);
        items_sent++;
        @(negedge i_clk);
    endtask

    // block must be idle before a register write
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // end any partial vector so the next one starts from a zero count
    task automatic flush_vector();
        int c;
        bit l;
        while (sb.vcount != 0) begin
            if (sb.acols < MAX_COLS) begin
                c = $urandom_range(sb.acols, MAX_COLS - 1);
            end else begin
                c = $urandom_range(0, MAX_COLS - 1);
            end
            l = !sb.multiply_unsafe(COL_W'(c), 1'b1);
            send_item(CMD_VECTOR, ROW_W'($urandom()), COL_W'(c), rand_q(), l);
        end
    endtask

    task automatic send_vector(bit well_formed, output int sent);
        int pos [MAX_COLS + 2];
        int len;
        int k;
        int tmp;
        bit l;
        sent = 0;
        if (well_formed) begin
            flush_vector();
            len = sb.acols;
            for (int i = 0; i < len; i++) pos[i] = i;
            for (int i = len - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = pos[i];
                pos[i] = pos[k];
                pos[k] = tmp;
            end
        end else begin
            len = $urandom_range(1, sb.acols + 2);
            for (int i = 0; i < len; i++) begin
                pos[i] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_COLS - 1)
                                                     : $urandom_range(0, sb.acols - 1);
            end
        end
        for (int i = 0; i < len; i++) begin
            l = (i == len - 1) && !sb.multiply_unsafe(COL_W'(pos[i]), i == len - 1);
            send_item(CMD_VECTOR, ROW_W'($urandom()), COL_W'(pos[i]), rand_q(), l);
            sent++;
        end
    endtask

    task automatic run_mix(int n);
        int done;
        int kind;
        int sent;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        bit l;
        done = 0;
        while (done < n) begin
            kind = $urandom_range(99);
            if ($urandom_range(0, 4) == 0) begin
                r = ROW_W'($urandom());
                c = COL_W'($urandom());
            end else begin
                r = ROW_W'($urandom_range(0, sb.eff_rows() - 1));
                c = COL_W'($urandom_range(0, sb.acols - 1));
            end
            if (kind < 30) begin
                send_item(CMD_WRITE, r, c, rand_q(), 1'($urandom()));
                done++;
            end else if (kind < 50) begin
                send_item(CMD_READ, r, c, rand_q(), 1'($urandom()));
                done++;
            end else if (kind < 55) begin
                send_item(CMD_SCALE, ROW_W'($urandom()), COL_W'($urandom()), rand_factor(),
                          1'($urandom()));
                done++;
            end else if (kind < 62) begin
                c = COL_W'($urandom());
                l = 1'($urandom()) && !sb.multiply_unsafe(c, 1'b1);
                send_item(CMD_VECTOR, ROW_W'($urandom()), c, rand_q(), l);
                done++;
            end else begin
                send_vector($urandom_range(0, 3) != 0, sent);
                done += sent;
            end
        end
        flush_vector();
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();

        // directed: 2x2 after reset, rails, saturation, range errors, vector cases
        idle_pct = 20;
        send_item(CMD_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(CMD_WRITE, 4'd0, 4'd1, 32'h8000_0000, 1'b1);
        send_item(CMD_WRITE, 4'd1, 4'd0, 32'h0001_0000, 1'b0);
        send_item(CMD_WRITE, 4'd1, 4'd1, 32'hFFFF_8000, 1'b0);
        send_item(CMD_READ, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_READ, 4'd1, 4'd1, 32'h0000_0000, 1'b1);
        send_item(CMD_WRITE, 4'd2, 4'd0, 32'h1234_5678, 1'b0);
        send_item(CMD_WRITE, 4'd0, 4'd2, 32'h1234_5678, 1'b0);
        send_item(CMD_READ, 4'd15, 4'd15, 32'h0000_0000, 1'b0);
        send_item(CMD_SCALE, 4'd0, 4'd0, 32'h0001_8000, 1'b0);
        send_item(CMD_READ, 4'd0, 4'd0, 32'h0000_0000, 1'b0);
        send_item(CMD_READ, 4'd0, 4'd1, 32'h0000_0000, 1'b0);
        send_item(CMD_READ, 4'd1, 4'd1, 32'h0000_0000, 1'b0);
        send_item(CMD_VECTOR, 4'd0, 4'd5, 32'h0001_0000, 1'b0);
        send_item(CMD_VECTOR, 4'd0, 4'd3, 32'h0001_0000, 1'b1);
        send_item(CMD_VECTOR, 4'd0, 4'd0, 32'h0001_0000, 1'b1);
        send_item(CMD_VECTOR, 4'd0, 4'd0, 32'h0002_0000, 1'b0);
        send_item(CMD_VECTOR, 4'd0, 4'd1, 32'hFFFF_0000, 1'b1);
        send_item(CMD_READ, 4'd0, 4'd1, 32'h0000_0000, 1'b0);
        send_item(CMD_READ, 4'd1, 4'd0, 32'h0000_0000, 1'b0);
        send_item(CMD_VECTOR, 4'd0, 4'd0, 32'h8000_0000, 1'b1);
        send_item(CMD_SCALE, 4'd0, 4'd0, 32'h8000_0000, 1'b0);
        send_item(CMD_READ, 4'd0, 4'd0, 32'h0000_0000, 1'b0);

        // full 16x16, then run the vector count into its ceiling
        quiesce();
        cfg_write(CFG_ROW_COUNT, DIM_W'(16));
        cfg_write(CFG_COL_COUNT, DIM_W'(16));
        idle_pct = 25;
        run_mix(45);
        repeat (33) begin
            send_item(CMD_VECTOR, ROW_W'($urandom()), COL_W'($urandom()), rand_q(), 1'b0);
        end
        flush_vector();

        // zero registers clamp to a 1x1 matrix
        quiesce();
        cfg_write(CFG_ROW_COUNT, DIM_W'(0));
        cfg_write(CFG_COL_COUNT, DIM_W'(0));
        idle_pct = 40;
        run_mix(20);

        // oversize registers clamp to 16x16, no idling on either side here
        quiesce();
        cfg_write(CFG_ROW_COUNT, DIM_W'(31));
        cfg_write(CFG_COL_COUNT, DIM_W'(17));
        idle_pct = 0;
        run_mix(30);

        // writes to unused register indexes leave the store alone
        quiesce();
        cfg_write(CFG_IDX_W'(15), DIM_W'($urandom()));
        cfg_write(CFG_IDX_W'($urandom_range(2, 14)), DIM_W'($urandom()));
        idle_pct = 20;
        run_mix(15);

        quiesce();
        cfg_write(CFG_ROW_COUNT, DIM_W'(5));
        cfg_write(CFG_COL_COUNT, DIM_W'(3));
        idle_pct = 15;
        run_mix(35);

        quiesce();
        cfg_write(CFG_ROW_COUNT, DIM_W'($urandom()));
        cfg_write(CFG_COL_COUNT, DIM_W'($urandom()));
        idle_pct = 30;
        run_mix(30);

        quiesce();
        quiet = 1'b1;
        cfg_write(CFG_ROW_COUNT, DIM_W'(16));
        cfg_write(CFG_COL_COUNT, DIM_W'(4));
        run_mix(30);

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d input words and %0d register writes, checked %0d result words",
                 items_sent, sb.cfg_writes, sb.words_seen);
        $display("including %0d matrix-vector products across clamped and full-size shapes",
                 sb.matvecs);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
